// ----- design/psu_pkg.sv -----
// Shared constants, types and the Paeth predictor for the PNG scanline unfilter.
// No dependencies; used by psu_recon and png_scanline_unfilter_unit.
package psu_pkg;

  localparam int LINE_DEPTH = 8192;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int PIX_MAX    = 8;
  localparam int PIX_IDX_W  = $clog2(PIX_MAX);
  localparam int BPP_W      = 4;
  localparam int LEN_W      = 14;
  localparam int CFG_W      = 14;

  // register indexes on the configuration port
  localparam logic [0:0] REG_BYTES_PER_PIXEL = 1'b0;
  localparam logic [0:0] REG_LINE_BYTES      = 1'b1;

  // filter type codes
  localparam logic [7:0] FILT_NONE  = 8'd0;
  localparam logic [7:0] FILT_SUB   = 8'd1;
  localparam logic [7:0] FILT_UP    = 8'd2;
  localparam logic [7:0] FILT_AVG   = 8'd3;
  localparam logic [7:0] FILT_PAETH = 8'd4;

  // one item moving from the address stage into the reconstruct stage
  typedef struct packed {
    logic                 go;
    logic                 has_left;
    logic                 nop;
    logic [7:0]           filtered;
    logic [7:0]           ftype;
    logic [PIX_IDX_W-1:0] pix_idx;
  } psu_step_t;

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [9:0] da;
    logic signed [9:0] db;
    logic signed [9:0] dc;
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    // pa = |b - c|, pb = |a - c|, pc = |a + b - 2c|
    da = $signed({2'b00, b}) - $signed({2'b00, c});
    db = $signed({2'b00, a}) - $signed({2'b00, c});
    dc = da + db;
    pa = da[9] ? 10'(-da) : 10'(da);
    pb = db[9] ? 10'(-db) : 10'(db);
    pc = dc[9] ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      paeth = a;
    end else if (pb <= pc) begin
      paeth = b;
    end else begin
      paeth = c;
    end
  endfunction

endpackage

// ----- design/psu_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module psu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/psu_recon.sv -----
// Reconstruct stage: left / above-left byte history and the five PNG filters.
// Depends on psu_pkg.
module psu_recon (
  input  logic              clk,
  input  logic              rst,
  input  psu_pkg::psu_step_t step,
  input  logic [7:0]        above_raw,
  output logic [7:0]        recon,
  output logic              bad
);

  logic [7:0] left_hist  [psu_pkg::PIX_MAX];
  logic [7:0] upper_hist [psu_pkg::PIX_MAX];
  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] c;
  logic [8:0] sum_ab;
  logic [7:0] pred;

  assign a      = step.has_left ? left_hist[step.pix_idx] : 8'd0;
  assign b      = step.nop ? 8'd0 : above_raw;
  assign c      = (!step.nop && step.has_left) ? upper_hist[step.pix_idx] : 8'd0;
  assign sum_ab = {1'b0, a} + {1'b0, b};

  always_comb begin
    bad = 1'b0;
    case (step.ftype)
      psu_pkg::FILT_NONE:  pred = 8'd0;
      psu_pkg::FILT_SUB:   pred = a;
      psu_pkg::FILT_UP:    pred = b;
      psu_pkg::FILT_AVG:   pred = sum_ab[8:1];
      psu_pkg::FILT_PAETH: pred = psu_pkg::paeth(a, b, c);
      default: begin
        pred = 8'd0;
        bad  = 1'b1;
      end
    endcase
  end

  assign recon = step.filtered + pred;

  // newest first; shifts once per reconstructed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < psu_pkg::PIX_MAX; i++) begin
        left_hist[i]  <= 8'd0;
        upper_hist[i] <= 8'd0;
      end
    end else if (step.go) begin
      for (int i = psu_pkg::PIX_MAX - 1; i > 0; i--) begin
        left_hist[i]  <= left_hist[i-1];
        upper_hist[i] <= upper_hist[i-1];
      end
      left_hist[0]  <= recon;
      upper_hist[0] <= b;
    end
  end

endmodule

// ----- design/png_scanline_unfilter_unit.sv -----
// PNG scanline unfilter (filter method 0). Takes one filtered byte per clock while in_ready
// is high, with its line's filter type and a no-previous-line flag, and returns one
// reconstructed byte per item, with bad_filter set for filter types above 4 (byte passed
// through) and last_of_line on the final byte of each scanline. Sustained rate is one item
// per clock when out_ready does not stall the output. The accepting edge loads stage 1
// and issues the synchronous read of the previous-line RAM (8192 x 8); the filter math
// runs on the stage-1 item and is registered into the output register when stage 1 moves
// on. The line RAM is read when an item is accepted and written when that item leaves
// the reconstruct stage; a one-byte line, where read and write hit the same entry back
// to back, is covered by a forward path. The RAM needs no clearing: above bytes of a line
// that was never written must not be used (set no_previous_line).
// Depends on psu_pkg, psu_ram, psu_recon.
module png_scanline_unfilter_unit (
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_index,
  input  logic [psu_pkg::CFG_W-1:0]  cfg_data,
  // input items
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 filtered_byte,
  input  logic [7:0]                 filter_type,
  input  logic                       no_previous_line,
  // result items
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 recon_byte,
  output logic                       bad_filter,
  output logic                       last_of_line
);

  // config registers
  logic [psu_pkg::BPP_W-1:0]     bytes_per_pixel;
  logic [psu_pkg::LEN_W-1:0]     line_bytes;
  logic [psu_pkg::BPP_W-1:0]     bpp_eff;
  logic [psu_pkg::LEN_W-1:0]     len_eff;

  // address stage
  logic [psu_pkg::ADDR_W-1:0]    byte_position;
  logic [psu_pkg::ADDR_W-1:0]    pos_eff;
  logic [psu_pkg::LEN_W-1:0]     pos_inc;
  logic                          pos_last;
  logic                          in_acc;

  // reconstruct stage
  logic                          s1_valid;
  logic                          s1_go;
  logic [psu_pkg::ADDR_W-1:0]    s1_addr;
  logic                          s1_has_left;
  logic                          s1_nop;
  logic [7:0]                    s1_byte;
  logic [7:0]                    s1_ftype;
  logic                          s1_last;
  logic                          s1_fwd;
  logic [7:0]                    s1_fwd_data;
  logic [7:0]                    ram_rdata;
  logic [7:0]                    above_raw;
  logic [7:0]                    recon;
  logic                          bad;
  psu_pkg::psu_step_t            step;

  // ---------------------------------------------------------------------------
  // Configuration: clamp to the legal ranges (zero means one, big values saturate)
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= psu_pkg::BPP_W'(1);
      line_bytes      <= psu_pkg::LEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        psu_pkg::REG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[psu_pkg::BPP_W-1:0];
        psu_pkg::REG_LINE_BYTES:      line_bytes      <= cfg_data[psu_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (bytes_per_pixel == '0) begin
      bpp_eff = psu_pkg::BPP_W'(1);
    end else if (bytes_per_pixel > psu_pkg::BPP_W'(psu_pkg::PIX_MAX)) begin
      bpp_eff = psu_pkg::BPP_W'(psu_pkg::PIX_MAX);
    end else begin
      bpp_eff = bytes_per_pixel;
    end
    if (line_bytes == '0) begin
      len_eff = psu_pkg::LEN_W'(1);
    end else if (line_bytes > psu_pkg::LEN_W'(psu_pkg::LINE_DEPTH)) begin
      len_eff = psu_pkg::LEN_W'(psu_pkg::LINE_DEPTH);
    end else begin
      len_eff = line_bytes;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: stage 1 moves on when the output register is free or being drained
  // ---------------------------------------------------------------------------
  assign s1_go    = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;
  assign in_acc   = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Address stage: byte position, line end, RAM read issue
  // ---------------------------------------------------------------------------
  // a position past a shrunken line restarts the line
  assign pos_eff  = ({1'b0, byte_position} >= len_eff) ? '0 : byte_position;
  assign pos_inc  = {1'b0, pos_eff} + psu_pkg::LEN_W'(1);
  assign pos_last = pos_inc >= len_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (in_acc) begin
      byte_position <= pos_last ? '0 : pos_inc[psu_pkg::ADDR_W-1:0];
    end
  end

  psu_ram #(
    .WIDTH (8),
    .DEPTH (psu_pkg::LINE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_addr),
    .wdata (recon),
    .re    (in_acc),
    .raddr (pos_eff),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 1 register. The forward flag catches a read of the entry that the
  // departing item writes in the same cycle (one-byte lines).
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_addr     <= pos_eff;
      s1_has_left <= {1'b0, pos_eff} >= {{(psu_pkg::LEN_W-psu_pkg::BPP_W){1'b0}}, bpp_eff};
      s1_nop      <= no_previous_line;
      s1_byte     <= filtered_byte;
      s1_ftype    <= filter_type;
      s1_last     <= pos_last;
      s1_fwd      <= s1_go && (s1_addr == pos_eff);
      s1_fwd_data <= recon;
    end
  end

  assign above_raw = s1_fwd ? s1_fwd_data : ram_rdata;

  always_comb begin
    step          = '0;
    step.go       = s1_go;
    step.has_left = s1_has_left;
    step.nop      = s1_nop;
    step.filtered = s1_byte;
    step.ftype    = s1_ftype;
    step.pix_idx  = psu_pkg::PIX_IDX_W'(bpp_eff - psu_pkg::BPP_W'(1));
  end

  psu_recon u_recon (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .above_raw (above_raw),
    .recon     (recon),
    .bad       (bad)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      recon_byte   <= recon;
      bad_filter   <= bad;
      last_of_line <= s1_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a held stage-1 item is never overwritten by a new accept
  a_s1_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |-> !in_acc)
    else $error("stage 1 item overwritten while stalled");

  // same-entry read during write-back must select the forward path
  a_fwd_taken: assert property (@(posedge clk) disable iff (rst)
    in_acc && s1_go && (s1_addr == pos_eff) |=> s1_fwd && s1_valid)
    else $error("line RAM forward missed");

  // the item after a line end starts at position zero
  a_line_wrap: assert property (@(posedge clk) disable iff (rst)
    in_acc && pos_last |=> byte_position == '0)
    else $error("byte position did not wrap at line end");

endmodule
